// ===== hdl/lmch_pkg.sv =====
// Package for the LPC memory cycle host: beat types, frame clock numbers and bus codes.
`timescale 1ns / 1ps

package lmch_pkg;

   // Parameter defaults
   localparam int DEFAULT_ADDRESS_BITS = 24;
   localparam int DEFAULT_COUNT_BITS   = 25;

   // Frame clock numbers; zero marks an idle bus
   localparam int PHASE_BITS = 5;
   localparam logic [PHASE_BITS-1:0] PH_IDLE      = 5'd0;
   localparam logic [PHASE_BITS-1:0] PH_START     = 5'd1;
   localparam logic [PHASE_BITS-1:0] PH_CYCTYPE   = 5'd2;
   localparam logic [PHASE_BITS-1:0] PH_ADDR_LAST = 5'd10;
   localparam logic [PHASE_BITS-1:0] PH_WDATA_LO  = 5'd11;
   localparam logic [PHASE_BITS-1:0] PH_WDATA_HI  = 5'd12;
   localparam logic [PHASE_BITS-1:0] PH_RTAR1     = 5'd12;
   localparam logic [PHASE_BITS-1:0] PH_SYNC      = 5'd13;
   localparam logic [PHASE_BITS-1:0] PH_RDATA_LO  = 5'd14;
   localparam logic [PHASE_BITS-1:0] PH_RDATA_HI  = 5'd15;
   localparam logic [PHASE_BITS-1:0] PH_TAR_OUT   = 5'd16;
   localparam logic [PHASE_BITS-1:0] PH_LAST      = 5'd17;

   // LAD nibble codes
   localparam logic [3:0] NIB_START = 4'b0000;
   localparam logic [3:0] CYC_READ  = 4'b0100;
   localparam logic [3:0] CYC_WRITE = 4'b0110;
   localparam logic [3:0] NIB_IDLE  = 4'b1111;

   // Operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic        start_req;
      logic        operation;
      logic [23:0] start_address;
      logic [7:0]  write_data;
      logic [24:0] burst_count;
      logic [3:0]  lad_in;
   } lmch_req_type;

   typedef struct packed {
      logic [3:0] lad_out;
      logic       lad_drive;
      logic       lframe_low;
      logic       read_valid;
      logic [7:0] read_data;
      logic [3:0] sync_nibble;
      logic       busy_res;
      logic       last_of_burst;
   } lmch_rsp_type;

endpackage

// ===== hdl/lmch_in_stage.sv =====
// Input register of the LPC memory cycle host: holds one request beat.
`timescale 1ns / 1ps

module lmch_in_stage
   import lmch_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lmch_req_type req_data,
   input  logic         take,
   output logic         item_valid,
   output lmch_req_type item_data
);

   logic         valid_ff, valid_in;
   lmch_req_type data_ff;

   // Accept when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// ===== hdl/lmch_frame_core.sv =====
// Frame sequencer of the LPC memory cycle host: bus state and per-clock result logic.
`timescale 1ns / 1ps

module lmch_frame_core
   import lmch_pkg::*;
#(
   parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS,
   parameter int COUNT_BITS   = DEFAULT_COUNT_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  lmch_req_type item,
   output lmch_rsp_type result
);

   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic                    is_write_ff, is_write_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [COUNT_BITS-1:0]   frames_ff, frames_in;
   logic [7:0]              wbyte_ff, wbyte_in;
   logic [7:0]              rbyte_ff, rbyte_in;
   logic [3:0]              sync_ff, sync_in;

   logic [31:0]             addr_wide, cnt_wide, bus_addr;
   logic [COUNT_BITS-1:0]   cnt_load, frames_dec;
   logic [2:0]              addr_k;
   logic [PHASE_BITS-1:0]   p;
   logic                    idle, start;
   logic [3:0]              nib;
   logic                    drive, lframe, rvalid, busy, last;
   logic [7:0]              rdata;

   always_comb begin
      addr_wide = 32'(item.start_address);
      cnt_wide  = 32'(item.burst_count);
      cnt_load  = cnt_wide[COUNT_BITS-1:0];
      idle      = (phase_ff == PH_IDLE) || (phase_ff > PH_LAST);
      start     = idle && item.start_req;

      // Load a new access when idle, else keep the running one
      is_write_in = is_write_ff;
      addr_in     = addr_ff;
      wbyte_in    = wbyte_ff;
      frames_in   = frames_ff;
      p           = idle ? PH_IDLE : phase_ff;
      if (start) begin
         is_write_in = item.operation;
         addr_in     = addr_wide[ADDRESS_BITS-1:0];
         wbyte_in    = item.write_data;
         frames_in   = (cnt_load == '0 || item.operation == OP_WRITE) ?
                       COUNT_BITS'(1) : cnt_load;
         p           = PH_START;
      end

      // Upper address bits go out as ones
      bus_addr = {{(32 - ADDRESS_BITS){1'b1}}, addr_in};
      addr_k   = 3'(PH_ADDR_LAST - p);

      nib        = NIB_IDLE;
      drive      = 1'b1;
      lframe     = 1'b0;
      rvalid     = 1'b0;
      rdata      = 8'h00;
      busy       = 1'b0;
      last       = 1'b0;
      rbyte_in   = rbyte_ff;
      sync_in    = sync_ff;
      phase_in   = PH_IDLE;
      frames_dec = '0;

      // Drive or sample the bus for this frame clock
      if (p != PH_IDLE) begin
         busy = 1'b1;
         if (p == PH_START) begin
            nib    = NIB_START;
            lframe = 1'b1;
         end else if (p == PH_CYCTYPE) begin
            nib = is_write_in ? CYC_WRITE : CYC_READ;
         end else if (p <= PH_ADDR_LAST) begin
            nib = bus_addr[addr_k*4 +: 4];
         end else if (is_write_in) begin
            case (p) inside
               PH_WDATA_LO: nib = wbyte_in[3:0];
               PH_WDATA_HI: nib = wbyte_in[7:4];
               [PH_RDATA_LO:PH_TAR_OUT]: drive = 1'b0;
               PH_LAST: last = 1'b1;
               default: ;
            endcase
         end else begin
            case (p) inside
               PH_RTAR1, PH_TAR_OUT: drive = 1'b0;
               PH_SYNC: begin
                  drive   = 1'b0;
                  sync_in = item.lad_in;
               end
               PH_RDATA_LO: begin
                  drive    = 1'b0;
                  rbyte_in = {rbyte_ff[7:4], item.lad_in};
               end
               PH_RDATA_HI: begin
                  drive    = 1'b0;
                  rbyte_in = {item.lad_in, rbyte_ff[3:0]};
                  rvalid   = 1'b1;
                  rdata    = rbyte_in;
                  last     = (frames_in == COUNT_BITS'(1));
               end
               default: ;
            endcase
         end

         // Step the clock number; at the end close the frame or repeat a read burst
         if (p < PH_LAST) begin
            phase_in = p + PHASE_BITS'(1);
         end else begin
            frames_dec = frames_in - COUNT_BITS'(1);
            if (!is_write_in) begin
               addr_in = addr_in + ADDRESS_BITS'(1);
            end
            if (frames_dec != '0 && !is_write_in) begin
               phase_in  = PH_START;
               frames_in = frames_dec;
            end else begin
               phase_in  = PH_IDLE;
               frames_in = '0;
            end
         end
      end

      result.lad_out       = nib;
      result.lad_drive     = drive;
      result.lframe_low    = lframe;
      result.read_valid    = rvalid;
      result.read_data     = rdata;
      result.sync_nibble   = sync_in;
      result.busy_res      = busy;
      result.last_of_burst = last;
   end

   // Commit state once per tick handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         is_write_ff <= 1'b0;
         addr_ff     <= '0;
         frames_ff   <= '0;
         wbyte_ff    <= '0;
         rbyte_ff    <= '0;
         sync_ff     <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         is_write_ff <= is_write_in;
         addr_ff     <= addr_in;
         frames_ff   <= frames_in;
         wbyte_ff    <= wbyte_in;
         rbyte_ff    <= rbyte_in;
         sync_ff     <= sync_in;
      end
   end

endmodule

// ===== hdl/lmch_out_stage.sv =====
// Output register of the LPC memory cycle host: holds one result beat for the receiver.
`timescale 1ns / 1ps

module lmch_out_stage
   import lmch_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  lmch_rsp_type load_data,
   output logic         space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lmch_rsp_type rsp_data
);

   logic         valid_ff, valid_in;
   lmch_rsp_type data_ff;

   // Room when empty or when the held beat leaves this cycle
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hdl/lpc_memory_cycle_host.sv =====
// Top level of the LPC memory cycle host.
//
// Every request beat is one LPC clock tick: an optional start request (burst
// memory read or single memory write) plus the LAD nibble sampled on that tick.
// Every request beat yields exactly one response beat with the LAD nibble to
// drive, the drive enable, LFRAME, and read byte, SYNC and status flags.
// Starts arriving while busy are dropped.
//
// Path: a request passes the input register, one pass of frame logic and the
// output register.
// Throughput: one beat per cycle while rsp_ready is high; the input register
// refills while the output register is taken, so both sides run at full rate.
// Stall: when rsp_ready is low the response holds and the input register
// fills, after which req_ready drops until the receiver takes a beat. The bus
// state advances only when a tick moves into the output register.
// Reset: all frame state clears to an idle bus; both registers empty.
`timescale 1ns / 1ps

module lpc_memory_cycle_host
   import lmch_pkg::*;
#(
   parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS,
   parameter int COUNT_BITS   = DEFAULT_COUNT_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lmch_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lmch_rsp_type rsp_data
);

   logic         item_valid, space, advance;
   lmch_req_type item_data;
   lmch_rsp_type result;

   // Hand a tick on when it is held and the output register has room
   assign advance = item_valid && space;

   lmch_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   lmch_frame_core #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_frame_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_data),
      .result  (result)
   );

   lmch_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/lmch_checker.sv =====
// Port checker for the LPC memory cycle host, bound to the top level.
`timescale 1ns / 1ps

module lmch_checker
   import lmch_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input lmch_rsp_type rsp_data
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // START clock drives 0000 with LFRAME inside a busy frame
   a_start_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lframe_low |->
         rsp_data.lad_out == NIB_START && rsp_data.lad_drive && rsp_data.busy_res)
      else $error("bad START clock");

   // Released bus reads as F and only happens in a frame
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.lad_drive |->
         rsp_data.lad_out == NIB_IDLE && rsp_data.busy_res)
      else $error("bad released bus clock");

   // Read byte arrives with the bus released and never on the START clock
   a_read_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_valid |->
         !rsp_data.lad_drive && !rsp_data.lframe_low && rsp_data.busy_res)
      else $error("read byte outside a read frame");

endmodule

bind lpc_memory_cycle_host lmch_checker u_checker (.*);
